@@ sv/dqpt_pkg.sv @@
package dqpt_pkg;

    localparam int NUM_REGS  = 8;
    localparam int REG_IDX_W = 3;
    // binary point of the point coordinates
    localparam int POINT_FRAC = 8;
    // translation is doubled and brought to the point's scale
    localparam int TR_SHIFT = POINT_FRAC + 1;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_ROT_W  = 3'd0,
        REG_ROT_X  = 3'd1,
        REG_ROT_Y  = 3'd2,
        REG_ROT_Z  = 3'd3,
        REG_DUAL_W = 3'd4,
        REG_DUAL_X = 3'd5,
        REG_DUAL_Y = 3'd6,
        REG_DUAL_Z = 3'd7
    } t_reg_idx;

endpackage

@@ sv/dqpt_pipe.sv @@
module dqpt_pipe
    import dqpt_pkg::*;
#(
    parameter int POINT_WIDTH = 24,
    parameter int COEF_WIDTH  = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic [NUM_REGS-1:0][COEF_WIDTH-1:0]   i_coef,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [POINT_WIDTH-1:0]         i_px,
    input  logic signed [POINT_WIDTH-1:0]         i_py,
    input  logic signed [POINT_WIDTH-1:0]         i_pz,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [POINT_WIDTH-1:0]                o_x,
    output logic [POINT_WIDTH-1:0]                o_y,
    output logic [POINT_WIDTH-1:0]                o_z,
    output logic                                  o_sat
);

    localparam int PW   = POINT_WIDTH;
    localparam int CW   = COEF_WIDTH;
    localparam int PPW  = PW + CW;            // coef * point
    localparam int AW   = PPW + 2;            // r * p component
    localparam int DPW  = 2 * CW;             // coef * coef
    localparam int TW   = DPW + 2;            // d * conj(r) component
    localparam int MW   = AW + CW;            // (r * p) * coef
    localparam int SW   = PW + 2 * CW + 5;    // final sum
    localparam int SH   = 2 * (CW - 2);
    localparam int OW   = SW - SH;
    localparam int NSTG = 6;
    localparam logic [SW-1:0] HALF = SW'(1) << (SH - 1);

    logic signed [CW-1:0] rw, rx, ry, rz, dw, dx, dy, dz;
    assign rw = i_coef[REG_ROT_W];
    assign rx = i_coef[REG_ROT_X];
    assign ry = i_coef[REG_ROT_Y];
    assign rz = i_coef[REG_ROT_Z];
    assign dw = i_coef[REG_DUAL_W];
    assign dx = i_coef[REG_DUAL_X];
    assign dy = i_coef[REG_DUAL_Y];
    assign dz = i_coef[REG_DUAL_Z];

    // stage handshake: a stage moves when it is empty or the next one moves
    logic [NSTG:0]   adv;
    logic [NSTG-1:0] r_vld;

    always_comb begin
        adv[NSTG] = i_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign o_ready = adv[0];
    assign o_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 1: point capture
    logic signed [PW-1:0] r_px, r_py, r_pz;
    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_px <= i_px;
            r_py <= i_py;
            r_pz <= i_pz;
        end
    end

    // stage 2: r * p and d * conj(r) products
    logic signed [PPW-1:0] r_pp [12];
    logic signed [DPW-1:0] r_dp [12];
    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_pp[0]  <= PPW'(rx) * PPW'(r_px);
            r_pp[1]  <= PPW'(ry) * PPW'(r_py);
            r_pp[2]  <= PPW'(rz) * PPW'(r_pz);
            r_pp[3]  <= PPW'(rw) * PPW'(r_px);
            r_pp[4]  <= PPW'(ry) * PPW'(r_pz);
            r_pp[5]  <= PPW'(rz) * PPW'(r_py);
            r_pp[6]  <= PPW'(rw) * PPW'(r_py);
            r_pp[7]  <= PPW'(rx) * PPW'(r_pz);
            r_pp[8]  <= PPW'(rz) * PPW'(r_px);
            r_pp[9]  <= PPW'(rw) * PPW'(r_pz);
            r_pp[10] <= PPW'(rx) * PPW'(r_py);
            r_pp[11] <= PPW'(ry) * PPW'(r_px);
            r_dp[0]  <= DPW'(dw) * DPW'(rx);
            r_dp[1]  <= DPW'(dx) * DPW'(rw);
            r_dp[2]  <= DPW'(dy) * DPW'(rz);
            r_dp[3]  <= DPW'(dz) * DPW'(ry);
            r_dp[4]  <= DPW'(dw) * DPW'(ry);
            r_dp[5]  <= DPW'(dx) * DPW'(rz);
            r_dp[6]  <= DPW'(dy) * DPW'(rw);
            r_dp[7]  <= DPW'(dz) * DPW'(rx);
            r_dp[8]  <= DPW'(dw) * DPW'(rz);
            r_dp[9]  <= DPW'(dx) * DPW'(ry);
            r_dp[10] <= DPW'(dy) * DPW'(rx);
            r_dp[11] <= DPW'(dz) * DPW'(rw);
        end
    end

    // stage 3: quaternion sums
    logic signed [AW-1:0] r_aw, r_ax, r_ay, r_az;
    logic signed [TW-1:0] r_t3 [3];
    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r_aw <= -AW'(r_pp[0]) - AW'(r_pp[1]) - AW'(r_pp[2]);
            r_ax <=  AW'(r_pp[3]) + AW'(r_pp[4]) - AW'(r_pp[5]);
            r_ay <=  AW'(r_pp[6]) - AW'(r_pp[7]) + AW'(r_pp[8]);
            r_az <=  AW'(r_pp[9]) + AW'(r_pp[10]) - AW'(r_pp[11]);
            r_t3[0] <= -TW'(r_dp[0]) + TW'(r_dp[1]) - TW'(r_dp[2]) + TW'(r_dp[3]);
            r_t3[1] <= -TW'(r_dp[4]) + TW'(r_dp[5]) + TW'(r_dp[6]) - TW'(r_dp[7]);
            r_t3[2] <= -TW'(r_dp[8]) - TW'(r_dp[9]) + TW'(r_dp[10]) + TW'(r_dp[11]);
        end
    end

    // stage 4: (r * p) * conj(r) products
    logic signed [MW-1:0] r_mp [12];
    logic signed [TW-1:0] r_t4 [3];
    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r_mp[0]  <= MW'(r_aw) * MW'(rx);
            r_mp[1]  <= MW'(r_ax) * MW'(rw);
            r_mp[2]  <= MW'(r_ay) * MW'(rz);
            r_mp[3]  <= MW'(r_az) * MW'(ry);
            r_mp[4]  <= MW'(r_aw) * MW'(ry);
            r_mp[5]  <= MW'(r_ax) * MW'(rz);
            r_mp[6]  <= MW'(r_ay) * MW'(rw);
            r_mp[7]  <= MW'(r_az) * MW'(rx);
            r_mp[8]  <= MW'(r_aw) * MW'(rz);
            r_mp[9]  <= MW'(r_ax) * MW'(ry);
            r_mp[10] <= MW'(r_ay) * MW'(rx);
            r_mp[11] <= MW'(r_az) * MW'(rw);
            r_t4 <= r_t3;
        end
    end

    // stage 5: rotation plus scaled translation plus rounding half
    logic signed [SW-1:0] r_sum [3];
    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r_sum[0] <= -SW'(r_mp[0]) + SW'(r_mp[1]) - SW'(r_mp[2]) + SW'(r_mp[3])
                        + (SW'(r_t4[0]) <<< TR_SHIFT) + $signed(HALF);
            r_sum[1] <= -SW'(r_mp[4]) + SW'(r_mp[5]) + SW'(r_mp[6]) - SW'(r_mp[7])
                        + (SW'(r_t4[1]) <<< TR_SHIFT) + $signed(HALF);
            r_sum[2] <= -SW'(r_mp[8]) - SW'(r_mp[9]) + SW'(r_mp[10]) + SW'(r_mp[11])
                        + (SW'(r_t4[2]) <<< TR_SHIFT) + $signed(HALF);
        end
    end

    // stage 6: scale down and clamp
    logic [OW-1:0]  v    [3];
    logic [PW-1:0]  n_o  [3];
    logic [2:0]     n_sat;
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            v[c] = OW'(r_sum[c] >>> SH);
            if (!v[c][OW-1] && (|v[c][OW-2:PW-1])) begin
                n_o[c]   = {1'b0, {(PW-1){1'b1}}};
                n_sat[c] = 1'b1;
            end else if (v[c][OW-1] && !(&v[c][OW-2:PW-1])) begin
                n_o[c]   = {1'b1, {(PW-1){1'b0}}};
                n_sat[c] = 1'b1;
            end else begin
                n_o[c]   = v[c][PW-1:0];
                n_sat[c] = 1'b0;
            end
        end
    end

    logic [PW-1:0] r_ox, r_oy, r_oz;
    logic          r_osat;
    always_ff @(posedge i_clk) begin
        if (adv[5]) begin
            r_ox   <= n_o[0];
            r_oy   <= n_o[1];
            r_oz   <= n_o[2];
            r_osat <= |n_sat;
        end
    end

    assign o_x   = r_ox;
    assign o_y   = r_oy;
    assign o_z   = r_oz;
    assign o_sat = r_osat;

endmodule

@@ sv/dual_quat_point_transform_top.sv @@
// Applies a rigid transform, held as a dual quaternion r + d*eps in eight
// Q2.14 registers, to a stream of Q16.8 points: out = r p r* + 2 d r*, rounded
// to nearest (ties up) and clamped to the point range, with tuser set when any
// coordinate clamps. r is not normalized, so a non-unit r also scales. One
// point is taken per clock while the master side accepts results; the six
// stages hold the point, the first multiply level, the quaternion sums, the
// second multiply level, the final add and the clamp. Stalls on the master
// side fill empty stages before backing up the slave side. Registers must
// be written only while no point is in flight; the block does not enforce it.
module dual_quat_point_transform_top
    import dqpt_pkg::*;
#(
    parameter int POINT_WIDTH = 24,
    parameter int COEF_WIDTH  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [REG_IDX_W-1:0]          i_cfg_addr,
    input  logic [COEF_WIDTH-1:0]         i_cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // point_x, point_y, point_z, zero pad
    input  logic [((3*POINT_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // out_x, out_y, out_z, zero pad
    output logic [((3*POINT_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // saturated
    output logic                          m_axis_tuser
);

    localparam int PW = POINT_WIDTH;
    localparam int DW = ((3 * PW + 7) / 8) * 8;
    // rot_w starts at 1.0, all others at zero
    localparam logic [NUM_REGS-1:0][COEF_WIDTH-1:0] COEF_RST =
        (NUM_REGS * COEF_WIDTH)'(1) << (int'(REG_ROT_W) * COEF_WIDTH + COEF_WIDTH - 2);

    logic [NUM_REGS-1:0][COEF_WIDTH-1:0] r_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= COEF_RST;
        end else if (i_cfg_we) begin
            r_coef[i_cfg_addr] <= i_cfg_data;
        end
    end

    logic [PW-1:0] out_x, out_y, out_z;

    dqpt_pipe #(
        .POINT_WIDTH (POINT_WIDTH),
        .COEF_WIDTH  (COEF_WIDTH)
    ) u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_coef  (r_coef),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_px    ($signed(s_axis_tdata[PW-1:0])),
        .i_py    ($signed(s_axis_tdata[2*PW-1:PW])),
        .i_pz    ($signed(s_axis_tdata[3*PW-1:2*PW])),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_x     (out_x),
        .o_y     (out_y),
        .o_z     (out_z),
        .o_sat   (m_axis_tuser)
    );

    assign m_axis_tdata = DW'({out_z, out_y, out_x});

endmodule
